// File: rtl/srfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared constants, types and the CRC-8 byte update for the frame checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

    localparam int unsigned DATA_BYTES = 4;
    localparam int unsigned POS_W      = $clog2(DATA_BYTES + 1);

    localparam logic [7:0]  CRC_POLY   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [31:0] FAIL_GAS   = 32'hFFFF_FFFF;
    localparam logic [31:0] TVOC_MASK  = 32'h00FF_FFFF;
    localparam logic [31:0] FAIL_VER   = 32'h0000_0000;

    typedef enum logic [1:0] {
        CMD_VERSION = 2'd0,
        CMD_GAS     = 2'd1,
        CMD_TVOC    = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic        last;
        logic        ok;
        logic [31:0] word;
    } t_frame_res;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/srfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_if
// Valid/ready channels: reply byte input and checked reading output.
// ----------------------------------------------------------------------------
interface srfc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output cmd, output rx_byte, output frame_start,
                    input ready);
    modport sink   (input valid, input cmd, input rx_byte, input frame_start,
                    output ready);
endinterface

interface srfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] reading;
    logic        crc_ok;

    modport source (output valid, output reading, output crc_ok, input ready);
    modport sink   (input valid, input reading, input crc_ok, output ready);
endinterface

// File: rtl/srfc_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_frame
// Frame state: byte position, running CRC and big-endian word assembly.
// ----------------------------------------------------------------------------
module srfc_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [7:0]             i_byte,
    input  logic                   i_start,
    output srfc_pkg::t_frame_res   o_res
);

    srfc_pkg::t_pos r_pos;
    srfc_pkg::t_pos n_pos;
    logic [7:0]     r_crc;
    logic [7:0]     n_crc;
    logic [31:0]    r_word;
    logic [31:0]    n_word;

    srfc_pkg::t_pos eff_pos;
    logic [7:0]     eff_crc;
    logic [31:0]    eff_word;
    logic           is_data;

    always_comb begin
        eff_pos  = i_start ? '0 : r_pos;
        eff_crc  = i_start ? srfc_pkg::CRC_INIT : r_crc;
        eff_word = i_start ? 32'd0 : r_word;
        is_data  = (eff_pos < srfc_pkg::POS_W'(srfc_pkg::DATA_BYTES));

        o_res.last = !is_data;
        o_res.ok   = (i_byte == eff_crc);
        o_res.word = eff_word;

        n_pos  = r_pos;
        n_crc  = r_crc;
        n_word = r_word;
        if (i_take) begin
            if (is_data) begin
                n_pos  = eff_pos + srfc_pkg::POS_W'(1);
                n_crc  = srfc_pkg::crc_feed(eff_crc, i_byte);
                n_word = {eff_word[23:0], i_byte};
            end else begin
                n_pos  = '0;
                n_crc  = srfc_pkg::CRC_INIT;
                n_word = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= srfc_pkg::CRC_INIT;
            r_word <= 32'd0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_word <= n_word;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= srfc_pkg::POS_W'(srfc_pkg::DATA_BYTES))
        else $error("frame position beyond crc byte");

    a_clear_after_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_res.last) |=> (r_pos == '0 && r_crc == srfc_pkg::CRC_INIT))
        else $error("frame state not cleared after crc beat");

endmodule

// File: rtl/srfc_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_result
// Reading post-processing by command and the output register.
// ----------------------------------------------------------------------------
module srfc_result (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [1:0]             i_cmd,
    input  srfc_pkg::t_frame_res   i_res,
    output logic                   o_free,
    srfc_out_if.source             o_out
);

    logic        r_valid;
    logic [31:0] r_reading;
    logic        r_ok;
    logic [31:0] n_reading;
    logic [31:0] w;

    always_comb begin
        w = i_res.word;
        unique case (srfc_pkg::t_cmd'(i_cmd))
            srfc_pkg::CMD_GAS:
                n_reading = i_res.ok ? ((w << 6) + (w << 5) + (w << 2)) : srfc_pkg::FAIL_GAS;
            srfc_pkg::CMD_TVOC:
                n_reading = i_res.ok ? (w & srfc_pkg::TVOC_MASK) : srfc_pkg::TVOC_MASK;
            srfc_pkg::CMD_VERSION, srfc_pkg::CMD_UNUSED:
                n_reading = i_res.ok ? w : srfc_pkg::FAIL_VER;
            default:
                n_reading = srfc_pkg::FAIL_VER;
        endcase
    end

    assign o_free        = !r_valid || o_out.ready;
    assign o_out.valid   = r_valid;
    assign o_out.reading = r_reading;
    assign o_out.crc_ok  = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_reading <= n_reading;
            r_ok      <= i_res.ok;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result beat overwrote a pending beat");

    a_fail_gas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && !i_res.ok && i_cmd == srfc_pkg::CMD_GAS)
            |=> (r_reading == srfc_pkg::FAIL_GAS && !r_ok))
        else $error("gas failure value wrong");

endmodule

// File: rtl/sensor_reading_frame_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reading_frame_checker_core
// CRC-8 (poly 0x31, init 0xFF) check of five-byte sensor replies with
// big-endian assembly and per-command post-processing of the reading.
//
//   channel  dir  payload                          beat
//   i_in     in   cmd, rx_byte, frame_start        one reply byte
//   o_out    out  reading, crc_ok                  one checked reading
//
// one beat accepted per cycle unless a crc beat waits for the output slot
// input register feeds the frame state; crc beats load the output register
// data beats keep flowing while a reading waits; a crc beat waits for the slot
// synchronous active-low reset clears frame state and both valid flags
// ----------------------------------------------------------------------------
module sensor_reading_frame_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srfc_in_if.sink     i_in,
    srfc_out_if.source  o_out
);

    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [7:0] r_byte;
    logic       r_start;

    srfc_pkg::t_frame_res frame_res;
    logic                 out_free;
    logic                 consume;
    logic                 load;

    assign consume    = r_in_valid && (!frame_res.last || out_free);
    assign load       = consume && frame_res.last;
    assign i_in.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd   <= i_in.cmd;
            r_byte  <= i_in.rx_byte;
            r_start <= i_in.frame_start;
        end
    end

    srfc_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (consume),
        .i_byte  (r_byte),
        .i_start (r_start),
        .o_res   (frame_res)
    );

    srfc_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_cmd   (r_cmd),
        .i_res   (frame_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    a_data_never_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !frame_res.last) |-> i_in.ready)
        else $error("data beat stalled behind output");

    a_load_from_stored_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> r_in_valid)
        else $error("reading produced without a stored beat");

endmodule
